>>> hdl/stream_mean_variance_min_max_macros.svh
// Assertion helpers for the stream statistics block.
`ifndef STREAM_MEAN_VARIANCE_MIN_MAX_MACROS_SVH
`define STREAM_MEAN_VARIANCE_MIN_MAX_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SMV_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smv assertion failed");
// next-cycle implication
`define SMV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smv assertion failed");
`else
`define SMV_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SMV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/smv_pkg.sv
package smv_pkg;

   typedef enum logic [2:0] {
      PH_MUL_NSQ,
      PH_MUL_SS,
      PH_MUL_NN,
      PH_DIV_VAR,
      PH_DIV_MEAN,
      PH_SQRT
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic      accept;
      logic      load;
      logic      step;
      logic      out_load;
      phase_type phase;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> hdl/smv_ctrl.sv
module smv_ctrl
   import smv_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PW    = SQ_W + COUNT_BITS;
   localparam int DW    = PW + FRAC_BITS;
   localparam int VAR_W = 2 * SAMPLE_BITS - 2 + FRAC_BITS;
   localparam int XW    = VAR_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DW + 1);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] steps_m1;
   logic             accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      unique case (phase_ff)
         PH_MUL_NSQ:  steps_m1 = CNT_W'(COUNT_BITS - 1);
         PH_MUL_SS:   steps_m1 = CNT_W'(SUM_W - 1);
         PH_MUL_NN:   steps_m1 = CNT_W'(COUNT_BITS - 1);
         PH_DIV_VAR:  steps_m1 = CNT_W'(DW - 1);
         PH_DIV_MEAN: steps_m1 = CNT_W'(DW - 1);
         PH_SQRT:     steps_m1 = CNT_W'(XW / 2 - 1);
         default:     steps_m1 = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               state_in = ST_LOAD;
               phase_in = PH_MUL_NSQ;
            end
         end
         ST_LOAD: begin
            state_in = ST_STEP;
            cnt_in   = steps_m1;
         end
         ST_STEP: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (phase_ff == PH_SQRT) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LOAD;
                  phase_in = phase_type'(phase_ff + 1'b1);
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd.accept   = req_tvalid && (state_ff == ST_IDLE);
      cmd.load     = (state_ff == ST_LOAD);
      cmd.step     = (state_ff == ST_STEP);
      cmd.out_load = (state_ff == ST_FINISH) && status.out_free;
      cmd.phase    = phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MUL_NSQ;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hdl/smv_datapath.sv
module smv_datapath
   import smv_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dp_cmd_type                              cmd,
   input  logic [SAMPLE_BITS-1:0]                  sample,
   input  logic                                    last_sample,
   output dp_status_type                           status,
   input  logic                                    rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [COUNT_BITS-1:0]                   sample_count,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]        mean_q8,
   output logic [2*SAMPLE_BITS-2+FRAC_BITS-1:0]    variance_q8,
   output logic [SAMPLE_BITS-1+FRAC_BITS-1:0]      stdev_q8,
   output logic [SAMPLE_BITS-1:0]                  minimum,
   output logic [SAMPLE_BITS-1:0]                  maximum,
   output logic                                    count_overflow
);

   localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PW     = SQ_W + COUNT_BITS;
   localparam int DW     = PW + FRAC_BITS;
   localparam int DENW   = 2 * COUNT_BITS;
   localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;
   localparam int VAR_W  = 2 * SAMPLE_BITS - 2 + FRAC_BITS;
   localparam int XW     = VAR_W + FRAC_BITS;
   localparam int SD_W   = SAMPLE_BITS - 1 + FRAC_BITS;

   // running accumulators
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic                   ovf_ff, ovf_in;

   // snapshot of the finished set
   logic [COUNT_BITS-1:0]  n_ff;
   logic [SUM_W-1:0]       s_ff;
   logic [SQ_W-1:0]        ss_ff;
   logic [SAMPLE_BITS-1:0] smin_ff, smax_ff;
   logic                   sovf_ff;

   // shared engine
   logic [PW-1:0]     p_ff, p_in, a_ff, a_in, t_ff, t_in;
   logic [SUM_W-1:0]  b_ff, b_in;
   logic [DW-1:0]     d_ff, d_in, q_ff, q_in;
   logic [DENW-1:0]   den_ff, den_in, r_ff, r_in;
   logic [VAR_W-1:0]  var_ff, var_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [SD_W-1:0]   root_ff, root_in;
   logic [SD_W+1:0]   sr_ff, sr_in;

   logic [DENW:0]     r_shift;
   logic              r_ge;
   logic [SD_W+3:0]   sq_rem, sq_trial;
   logic              sq_ge;

   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      min_in = min_ff;
      max_in = max_ff;
      ovf_in = ovf_ff;
      if (cnt_ff == '1) begin
         ovf_in = 1'b1;
      end else begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + SUM_W'(sample);
         sq_in  = sq_ff + SQ_W'(sample) * SQ_W'(sample);
         if (sample < min_ff) min_in = sample;
         if (sample > max_ff) max_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         min_ff <= '1;
         max_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (last_sample) begin
            cnt_ff <= '0;
            sum_ff <= '0;
            sq_ff  <= '0;
            min_ff <= '1;
            max_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_in;
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
            min_ff <= min_in;
            max_ff <= max_in;
            ovf_ff <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && last_sample) begin
         n_ff    <= cnt_in;
         s_ff    <= sum_in;
         ss_ff   <= sq_in;
         smin_ff <= min_in;
         smax_ff <= max_in;
         sovf_ff <= ovf_in;
      end
   end

   // restoring divide and square-root steps
   assign r_shift  = {r_ff, d_ff[DW-1]};
   assign r_ge     = (r_shift >= {1'b0, den_ff});
   assign sq_rem   = {sr_ff, x_ff[XW-1 -: 2]};
   assign sq_trial = (SD_W + 4)'({root_ff, 2'b01});
   assign sq_ge    = (sq_rem >= sq_trial);

   always_comb begin
      p_in    = p_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      t_in    = t_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      r_in    = r_ff;
      var_in  = var_ff;
      mean_in = mean_ff;
      x_in    = x_ff;
      root_in = root_ff;
      sr_in   = sr_ff;
      if (cmd.load) begin
         unique case (cmd.phase)
            PH_MUL_NSQ: begin
               a_in = PW'(ss_ff);
               b_in = SUM_W'(n_ff);
               p_in = '0;
            end
            PH_MUL_SS: begin
               t_in = p_ff;
               a_in = PW'(s_ff);
               b_in = s_ff;
               p_in = '0;
            end
            PH_MUL_NN: begin
               t_in = t_ff - p_ff;
               a_in = PW'(n_ff);
               b_in = SUM_W'(n_ff);
               p_in = '0;
            end
            PH_DIV_VAR: begin
               den_in = p_ff[DENW-1:0];
               d_in   = {t_ff, {FRAC_BITS{1'b0}}};
               r_in   = '0;
               q_in   = '0;
            end
            PH_DIV_MEAN: begin
               var_in = q_ff[VAR_W-1:0];
               den_in = DENW'(n_ff);
               d_in   = DW'({s_ff, {FRAC_BITS{1'b0}}});
               r_in   = '0;
               q_in   = '0;
            end
            PH_SQRT: begin
               mean_in = q_ff[MEAN_W-1:0];
               x_in    = {var_ff, {FRAC_BITS{1'b0}}};
               root_in = '0;
               sr_in   = '0;
            end
            default: ;
         endcase
      end else if (cmd.step) begin
         unique case (cmd.phase)
            PH_MUL_NSQ, PH_MUL_SS, PH_MUL_NN: begin
               if (b_ff[0]) p_in = p_ff + a_ff;
               a_in = {a_ff[PW-2:0], 1'b0};
               b_in = {1'b0, b_ff[SUM_W-1:1]};
            end
            PH_DIV_VAR, PH_DIV_MEAN: begin
               r_in = r_ge ? DENW'(r_shift - {1'b0, den_ff}) : r_shift[DENW-1:0];
               q_in = {q_ff[DW-2:0], r_ge};
               d_in = {d_ff[DW-2:0], 1'b0};
            end
            PH_SQRT: begin
               sr_in   = sq_ge ? (SD_W + 2)'(sq_rem - sq_trial) : sq_rem[SD_W+1:0];
               root_in = {root_ff[SD_W-2:0], sq_ge};
               x_in    = {x_ff[XW-3:0], 2'b00};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      t_ff    <= t_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      r_ff    <= r_in;
      var_ff  <= var_in;
      mean_ff <= mean_in;
      x_ff    <= x_in;
      root_ff <= root_in;
      sr_ff   <= sr_in;
   end

   // result register
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sample_count   <= n_ff;
         mean_q8        <= mean_ff;
         variance_q8    <= var_ff;
         stdev_q8       <= root_ff;
         minimum        <= smin_ff;
         maximum        <= smax_ff;
         count_overflow <= sovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hdl/stream_mean_variance_min_max.sv
// Per-set streaming statistics: count, mean, variance, stdev, min, max.
// Input item channel (req_): one unsigned sample per item in req_tdata,
//   req_tlast marks the last sample of a set. Samples are accumulated at
//   one per cycle while the block is idle.
// Result channel (rsp_): one item per set, issued after its last sample.
// After the last sample the result is formed in turn by shift-add multiply
//   steps, restoring divide steps and square-root steps, each phase opened
//   by a load, and is then handed off into the result register.
//   A single shared shift/add/subtract unit does all of this work;
//   req_tready is low for that whole stretch.
// Samples after the count saturates are dropped and count_overflow is set.
// Reset clears the accumulators (min to all ones) and empties the result
//   register. A result held by a stalled receiver does not block new
//   samples; only the next set's final computation waits for the slot.
module stream_mean_variance_min_max
   import smv_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [SAMPLE_BITS-1:0] sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // from bit 0 up: sample_count, mean_q8, variance_q8, stdev_q8,
   // minimum, maximum, count_overflow
   output logic [((COUNT_BITS + 6*SAMPLE_BITS + 3*FRAC_BITS - 2 + 7)/8)*8-1:0] rsp_tdata
);

   localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;
   localparam int VAR_W  = 2 * SAMPLE_BITS - 2 + FRAC_BITS;
   localparam int SD_W   = SAMPLE_BITS - 1 + FRAC_BITS;
   localparam int RSP_USED = COUNT_BITS + MEAN_W + VAR_W + SD_W + 2 * SAMPLE_BITS + 1;
   localparam int RSP_W  = ((RSP_USED + 7) / 8) * 8;

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic [COUNT_BITS-1:0]  sample_count;
   logic [MEAN_W-1:0]      mean_q8;
   logic [VAR_W-1:0]       variance_q8;
   logic [SD_W-1:0]        stdev_q8;
   logic [SAMPLE_BITS-1:0] minimum, maximum;
   logic                   count_overflow;

   smv_ctrl #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tlast (req_tlast),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   smv_datapath #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sample        (req_tdata[SAMPLE_BITS-1:0]),
      .last_sample   (req_tlast),
      .status        (status),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .sample_count  (sample_count),
      .mean_q8       (mean_q8),
      .variance_q8   (variance_q8),
      .stdev_q8      (stdev_q8),
      .minimum       (minimum),
      .maximum       (maximum),
      .count_overflow(count_overflow)
   );

   assign rsp_tdata = RSP_W'({count_overflow, maximum, minimum, stdev_q8,
                              variance_q8, mean_q8, sample_count});

`include "stream_mean_variance_min_max_macros.svh"

   // the last sample of a set closes the input until its result is formed
   `SMV_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // a set always has at least one sample, so its extremes are ordered
   `SMV_ASSERT_IMPLY(a_min_le_max, clock, reset, rsp_tvalid, minimum <= maximum)
   // the square root never overshoots
   `SMV_ASSERT_IMPLY(a_sqrt_floor, clock, reset, rsp_tvalid, (2*SD_W)'(stdev_q8) * (2*SD_W)'(stdev_q8) <= (2*SD_W)'({variance_q8, {FRAC_BITS{1'b0}}}))

endmodule
